// ===== sv/fecc_pkg.sv =====
// ----------------------------------------------------------------------------
// fecc_pkg
// Shared codes for the flow excess conservation checker: operations, result
// status values and configuration register indexes.
// ----------------------------------------------------------------------------
package fecc_pkg;

  localparam int unsigned NODE_W   = 10;
  localparam int unsigned FLOW_W   = 31;
  localparam int unsigned EXCESS_W = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_SINK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEGATIVE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POSITIVE      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE         = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SINK_NEGATIVE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SINK_MISMATCH = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SINK_LARGE    = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINK       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_FLOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECTIVE  = 3'd4;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_HEAD = 3'b100
  } state_t;

endpackage

// ===== sv/flow_excess_conservation_check.sv =====
// ----------------------------------------------------------------------------
// flow_excess_conservation_check
// Per-node signed 64-bit flow excess with conservation and sink checks.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start/operation/tail_node/head_node/arc_flow and are taken
//   at a clock edge with start high and busy low. Configuration registers are
//   written over cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always
//   high and writes are expected only while the block is idle.
//   Results appear on status/node_excess for one cycle with result_valid.
//   The receiver cannot stall, so every result is final when shown.
// Sequence (steps from the accept edge):
//   add arc     : busy through read tail, write tail + read head, write head;
//                 no writes and no head step when either end is out of range
//   check/sink  : busy for the read step; its result is registered onto result_valid,
//                 but a check of the source or sink node gives no result
//   clear node  : never busy, entry written at the accept edge
//   Single read and write memory ports set this; one item is in work at a time.
// Reset:
//   rst (synchronous) restores register defaults, then a clearing pass zeroes
//   the memory, one entry per cycle, all NODE_DEPTH entries, busy held high.
//   Configuration writes are accepted during the pass.
// ----------------------------------------------------------------------------
module flow_excess_conservation_check #(
  parameter int NODE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  // item channel
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         operation,
  input  logic [fecc_pkg::NODE_W-1:0]        tail_node,
  input  logic [fecc_pkg::NODE_W-1:0]        head_node,
  input  logic [fecc_pkg::FLOW_W-1:0]        arc_flow,
  // result channel
  output logic                               result_valid,
  output logic [fecc_pkg::STATUS_W-1:0]      status,
  output logic signed [fecc_pkg::EXCESS_W-1:0] node_excess,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fecc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fecc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ADDR_W = $clog2(NODE_DEPTH);
  localparam int unsigned DEPTH_U = 32'(NODE_DEPTH);

  // configuration registers
  logic [fecc_pkg::NODE_W-1:0] node_count;
  logic [fecc_pkg::NODE_W-1:0] source_node;
  logic [fecc_pkg::NODE_W-1:0] sink_node;
  logic                        full_flow_mode;
  logic [fecc_pkg::FLOW_W-1:0] objective_value;

  // sequencer and item registers
  fecc_pkg::state_t            state, state_next;
  logic [1:0]                  op_q;
  logic [fecc_pkg::NODE_W-1:0] tail_q;
  logic [fecc_pkg::NODE_W-1:0] head_q;
  logic [fecc_pkg::FLOW_W-1:0] flow_q;
  logic [fecc_pkg::EXCESS_W-1:0] tail_wval;   // value written to the tail, for forwarding

  // memory interface
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [fecc_pkg::EXCESS_W-1:0] wr_data;
  logic [ADDR_W-1:0]             rd_addr;
  logic [fecc_pkg::EXCESS_W-1:0] rd_data;
  logic                          clr_busy;

  // result staging
  logic                          res_en;
  logic [fecc_pkg::STATUS_W-1:0] res_status;
  logic [fecc_pkg::EXCESS_W-1:0] res_excess;

  logic                          accept;
  logic                          tail_ok, head_ok, sink_ok;
  logic                          clear_hit;
  logic [fecc_pkg::EXCESS_W-1:0] flow_ext;
  logic [fecc_pkg::EXCESS_W-1:0] head_base;

  function automatic logic node_in_range(
    input logic [fecc_pkg::NODE_W-1:0] u,
    input logic [fecc_pkg::NODE_W-1:0] cnt
  );
    return (u != '0) && (u <= cnt) && (32'(u) < DEPTH_U);
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = clr_busy || (state != fecc_pkg::S_IDLE);
  assign accept    = start && !busy;

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= 10'd1023;
      source_node     <= 10'd1;
      sink_node       <= 10'd2;
      full_flow_mode  <= 1'b1;
      objective_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fecc_pkg::REG_NODE_COUNT: node_count      <= cfg_data[fecc_pkg::NODE_W-1:0];
        fecc_pkg::REG_SOURCE:     source_node     <= cfg_data[fecc_pkg::NODE_W-1:0];
        fecc_pkg::REG_SINK:       sink_node       <= cfg_data[fecc_pkg::NODE_W-1:0];
        fecc_pkg::REG_FULL_FLOW:  full_flow_mode  <= cfg_data[0];
        fecc_pkg::REG_OBJECTIVE:  objective_value <= cfg_data[fecc_pkg::FLOW_W-1:0];
        default: ;
      endcase
    end
  end

  assign tail_ok   = node_in_range(tail_q, node_count);
  assign head_ok   = node_in_range(head_q, node_count);
  assign sink_ok   = node_in_range(sink_node, node_count);
  assign flow_ext  = {{(fecc_pkg::EXCESS_W - fecc_pkg::FLOW_W){1'b0}}, flow_q};
  // head == tail: the read in the tail-write cycle sees the old entry
  assign head_base = (head_q == tail_q) ? tail_wval : rd_data;
  assign clear_hit = accept && (operation == fecc_pkg::OP_CLEAR)
                     && (32'(tail_node) < DEPTH_U);

  // read address: the item's first entry is read at its accept edge
  always_comb begin
    unique case (state)
      fecc_pkg::S_IDLE:
        rd_addr = (operation == fecc_pkg::OP_SINK) ? ADDR_W'(sink_node)
                                                   : ADDR_W'(tail_node);
      fecc_pkg::S_READ: rd_addr = ADDR_W'(head_q);
      fecc_pkg::S_HEAD: rd_addr = ADDR_W'(head_q);
      default:          rd_addr = ADDR_W'(head_q);
    endcase
  end

  // sequencer, write port and result decision
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = ADDR_W'(tail_q);
    wr_data    = '0;
    res_en     = 1'b0;
    res_status = fecc_pkg::ST_OK;
    res_excess = rd_data;
    unique case (state)
      fecc_pkg::S_IDLE: begin
        if (clear_hit) begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(tail_node);
        end
        if (accept && (operation != fecc_pkg::OP_CLEAR)) begin
          state_next = fecc_pkg::S_READ;
        end
      end
      fecc_pkg::S_READ: begin
        state_next = fecc_pkg::S_IDLE;
        unique case (op_q)
          fecc_pkg::OP_ADD: begin
            if (tail_ok && head_ok) begin
              wr_en      = 1'b1;
              wr_data    = rd_data - flow_ext;
              state_next = fecc_pkg::S_HEAD;
            end
          end
          fecc_pkg::OP_CHECK: begin
            if (!tail_ok) begin
              res_en     = 1'b1;
              res_status = fecc_pkg::ST_RANGE;
              res_excess = '0;
            end else if ((tail_q != source_node) && (tail_q != sink_node)) begin
              res_en = 1'b1;
              priority if (rd_data[fecc_pkg::EXCESS_W-1]) begin
                res_status = fecc_pkg::ST_NEGATIVE;
              end else if (full_flow_mode && (rd_data != '0)) begin
                res_status = fecc_pkg::ST_POSITIVE;
              end else begin
                res_status = fecc_pkg::ST_OK;
              end
            end
          end
          fecc_pkg::OP_SINK: begin
            res_en = 1'b1;
            if (!sink_ok) begin
              res_status = fecc_pkg::ST_RANGE;
              res_excess = '0;
            end else begin
              priority if (rd_data == {33'd0, objective_value}) begin
                res_status = fecc_pkg::ST_OK;
              end else if (rd_data[fecc_pkg::EXCESS_W-1]) begin
                res_status = fecc_pkg::ST_SINK_NEGATIVE;
              end else if (rd_data[fecc_pkg::EXCESS_W-1:fecc_pkg::FLOW_W] == '0) begin
                res_status = fecc_pkg::ST_SINK_MISMATCH;
              end else begin
                res_status = fecc_pkg::ST_SINK_LARGE;
              end
            end
          end
          default: ;  // clear never reaches this state
        endcase
      end
      fecc_pkg::S_HEAD: begin
        state_next = fecc_pkg::S_IDLE;
        wr_en      = 1'b1;
        wr_addr    = ADDR_W'(head_q);
        wr_data    = head_base + flow_ext;
      end
      default: state_next = fecc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fecc_pkg::S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_en;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      tail_q <= tail_node;
      head_q <= head_node;
      flow_q <= arc_flow;
    end
    if (state == fecc_pkg::S_READ) begin
      tail_wval <= wr_data;
    end
    if (res_en) begin
      status      <= res_status;
      node_excess <= res_excess;
    end
  end

  fecc_store #(
    .NODE_DEPTH (NODE_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  // results only follow a read cycle, so they never come back to back
  a_result_spacing: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe on consecutive cycles");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == fecc_pkg::S_READ))
    else $error("result without a preceding read cycle");

  a_head_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == fecc_pkg::S_HEAD) |-> $past(state == fecc_pkg::S_READ && op_q == fecc_pkg::OP_ADD))
    else $error("head write not preceded by a tail update");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (accept && operation != fecc_pkg::OP_CLEAR) |=> (state == fecc_pkg::S_READ))
    else $error("accepted item did not start its read");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !accept)
    else $error("item accepted during memory clearing pass");

endmodule

// ===== sv/fecc_store.sv =====
// ----------------------------------------------------------------------------
// fecc_store
// Excess memory: one write port, one registered read port, and a clearing
// pass after reset that zeroes one entry per cycle.
// ----------------------------------------------------------------------------
module fecc_store #(
  parameter int NODE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [$clog2(NODE_DEPTH)-1:0]     wr_addr,
  input  logic [fecc_pkg::EXCESS_W-1:0]     wr_data,
  input  logic [$clog2(NODE_DEPTH)-1:0]     rd_addr,
  output logic [fecc_pkg::EXCESS_W-1:0]     rd_data,
  output logic                              clr_busy
);

  localparam int ADDR_W = $clog2(NODE_DEPTH);

  logic [fecc_pkg::EXCESS_W-1:0] mem [NODE_DEPTH];
  logic [ADDR_W-1:0]             clr_cnt;
  logic                          clr_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_cnt    <= '0;
    end else if (clr_active) begin
      if (clr_cnt == ADDR_W'(NODE_DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign clr_busy = clr_active;

endmodule
